// ===== rtl/jtok_pkg.sv =====
package jtok_pkg;

    // Result kinds
    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_END   = 3'd1;
    localparam logic [2:0] KIND_PUNCT = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_EOT   = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ESCAPE   = 2'd1;
    localparam logic [1:0] ERR_HEX      = 2'd2;
    localparam logic [1:0] ERR_UNCLOSED = 2'd3;

    // Packed widths of the result stream
    localparam int VALUE_W    = 16;
    localparam int LINE_OUT_W = 16;
    localparam int DATA_BITS  = VALUE_W + 2 + LINE_OUT_W;
    localparam int OUT_DATA_W = ((DATA_BITS + 7) / 8) * 8;
    localparam int OUT_USER_W = 4;

    // One result item, without its last flag
    typedef struct packed {
        logic [2:0]            kind;
        logic                  is_string;
        logic [VALUE_W-1:0]    value;
        logic [1:0]            error_code;
        logic [LINE_OUT_W-1:0] line;
    } tok_res_t;

    // All results caused by one byte
    typedef struct packed {
        logic [1:0] count;
        tok_res_t   r0;
        tok_res_t   r1;
    } tok_batch_t;

endpackage

// ===== rtl/json_tokenizer_unit.sv =====
// JSON tokenizer. Takes JSON text one byte per transfer on s_axis, a zero
// byte closing the text, and produces token characters, token ends,
// punctuation tokens, end-of-text marks and errors on m_axis, each tagged
// with the current line number. A byte is registered on input, lexed from that
// register once the result register can take its results, and its results
// (none, one or two) land in a two-entry result register, so bytes flow at one per
// cycle while results are taken as fast as they appear; a byte that yields two
// results holds the input stream, as the output delivers one result per cycle
// while the receiver is ready. An error is sticky: every later byte gives one
// error result until reset.
module json_tokenizer_unit #(
    parameter int LINE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // ch
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [jtok_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // value, error_code, line, zero pad
    output logic [jtok_pkg::OUT_USER_W-1:0] m_axis_tuser,  // kind, is_string
    output logic                            m_axis_tlast
);
    import jtok_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;
    logic       can_load;
    logic       fire;
    tok_batch_t batch;
    tok_res_t   res;

    assign fire          = in_valid_reg && can_load;
    assign s_axis_tready = !in_valid_reg || fire;

    // Input register: hold a byte until the lexer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_ch_reg <= s_axis_tdata;
        end
    end

    jtok_lexer #(
        .LINE_BITS (LINE_BITS)
    ) u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .ch    (in_ch_reg),
        .batch (batch)
    );

    jtok_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .batch     (batch),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .out_last  (m_axis_tlast)
    );

    // Pack the result fields onto the stream
    assign m_axis_tdata = OUT_DATA_W'({res.line, res.error_code, res.value});
    assign m_axis_tuser = {res.is_string, res.kind};

endmodule

// ===== rtl/jtok_lexer.sv =====
module jtok_lexer #(
    parameter int LINE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          ch,
    output jtok_pkg::tok_batch_t batch
);
    import jtok_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_BARE,
        M_STR,
        M_ESC,
        M_HEX,
        M_ERR_ESC,
        M_ERR_HEX,
        M_ERR_OPEN
    } mode_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    mode_t                mode_reg, mode_next;
    logic [1:0]           hex_cnt_reg, hex_cnt_next;
    logic [15:0]          hex_acc_reg, hex_acc_next;
    logic [LINE_BITS-1:0] line_reg, line_next;

    logic                 in_error;
    logic                 hex_ok;
    logic [3:0]           hex_val;
    logic [15:0]          hex_acc_shift;
    logic [LINE_OUT_W-1:0] line_out;

    function automatic logic is_punct(input logic [7:0] c);
        return c == 8'h3A || c == 8'h2C || c == 8'h7B || c == 8'h7D
            || c == 8'h5B || c == 8'h5D;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == CH_LF;
    endfunction

    function automatic tok_res_t mk(input logic [2:0] k, input logic s,
                                    input logic [15:0] v, input logic [1:0] e,
                                    input logic [LINE_OUT_W-1:0] ln);
        tok_res_t r;
        r.kind       = k;
        r.is_string  = s;
        r.value      = v;
        r.error_code = e;
        r.line       = ln;
        return r;
    endfunction

    // Decode one hex digit of either case
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            hex_val = 4'(ch - 8'h30);
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            hex_val = 4'(ch - 8'h37);
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            hex_val = 4'(ch - 8'h57);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign hex_acc_shift = {hex_acc_reg[11:0], hex_val};

    assign in_error = (mode_reg == M_ERR_ESC) || (mode_reg == M_ERR_HEX)
                   || (mode_reg == M_ERR_OPEN);

    // Count lines, saturating, frozen once an error is held
    always_comb
    begin
        line_next = line_reg;
        if (!in_error && ch == CH_LF && line_reg != {LINE_BITS{1'b1}})
        begin
            line_next = line_reg + LINE_BITS'(1);
        end
    end

    assign line_out = LINE_OUT_W'(line_next);

    // Lexer step: next mode and results for the current byte
    always_comb
    begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        hex_acc_next = hex_acc_reg;
        batch.count  = 2'd0;
        batch.r0     = mk(KIND_CHAR, 1'b0, 16'd0, ERR_NONE, line_out);
        batch.r1     = mk(KIND_CHAR, 1'b0, 16'd0, ERR_NONE, line_out);
        unique case (mode_reg)
            M_IDLE:
            begin
                priority if (ch == CH_NUL)
                begin
                    batch.count = 2'd1;
                    batch.r0    = mk(KIND_EOT, 1'b0, 16'd0, ERR_NONE, line_out);
                end
                else if (is_space(ch))
                begin
                end
                else if (is_punct(ch))
                begin
                    batch.count = 2'd1;
                    batch.r0    = mk(KIND_PUNCT, 1'b0, {8'd0, ch}, ERR_NONE, line_out);
                end
                else if (ch == CH_QUOTE)
                begin
                    mode_next = M_STR;
                end
                else
                begin
                    batch.count = 2'd1;
                    batch.r0    = mk(KIND_CHAR, 1'b0, {8'd0, ch}, ERR_NONE, line_out);
                    mode_next   = M_BARE;
                end
            end
            M_BARE:
            begin
                batch.r0 = mk(KIND_END, 1'b0, 16'd0, ERR_NONE, line_out);
                priority if (ch == CH_NUL)
                begin
                    batch.count = 2'd2;
                    batch.r1    = mk(KIND_EOT, 1'b0, 16'd0, ERR_NONE, line_out);
                    mode_next   = M_IDLE;
                end
                else if (is_space(ch))
                begin
                    batch.count = 2'd1;
                    mode_next   = M_IDLE;
                end
                else if (is_punct(ch))
                begin
                    batch.count = 2'd2;
                    batch.r1    = mk(KIND_PUNCT, 1'b0, {8'd0, ch}, ERR_NONE, line_out);
                    mode_next   = M_IDLE;
                end
                else if (ch == CH_QUOTE)
                begin
                    batch.count = 2'd1;
                    mode_next   = M_STR;
                end
                else
                begin
                    batch.count = 2'd1;
                    batch.r0    = mk(KIND_CHAR, 1'b0, {8'd0, ch}, ERR_NONE, line_out);
                end
            end
            M_STR:
            begin
                batch.count = 2'd1;
                priority if (ch == CH_NUL)
                begin
                    batch.r0  = mk(KIND_ERROR, 1'b0, 16'd0, ERR_UNCLOSED, line_out);
                    mode_next = M_ERR_OPEN;
                end
                else if (ch == CH_BSL)
                begin
                    batch.count = 2'd0;
                    mode_next   = M_ESC;
                end
                else if (ch == CH_QUOTE)
                begin
                    batch.r0  = mk(KIND_END, 1'b1, 16'd0, ERR_NONE, line_out);
                    mode_next = M_IDLE;
                end
                else
                begin
                    batch.r0 = mk(KIND_CHAR, 1'b1, {8'd0, ch}, ERR_NONE, line_out);
                end
            end
            M_ESC:
            begin
                mode_next   = M_STR;
                batch.count = 2'd1;
                priority if (ch == CH_NUL)
                begin
                    batch.r0  = mk(KIND_ERROR, 1'b0, 16'd0, ERR_UNCLOSED, line_out);
                    mode_next = M_ERR_OPEN;
                end
                else if (ch == 8'h62)
                begin
                    batch.r0 = mk(KIND_CHAR, 1'b1, 16'h0008, ERR_NONE, line_out);
                end
                else if (ch == 8'h6E)
                begin
                    batch.r0 = mk(KIND_CHAR, 1'b1, 16'h000A, ERR_NONE, line_out);
                end
                else if (ch == 8'h72)
                begin
                    batch.r0 = mk(KIND_CHAR, 1'b1, 16'h000D, ERR_NONE, line_out);
                end
                else if (ch == 8'h74)
                begin
                    batch.r0 = mk(KIND_CHAR, 1'b1, 16'h0009, ERR_NONE, line_out);
                end
                else if (ch == 8'h2F || ch == CH_BSL || ch == CH_QUOTE)
                begin
                    batch.r0 = mk(KIND_CHAR, 1'b1, {8'd0, ch}, ERR_NONE, line_out);
                end
                else if (ch == 8'h75)
                begin
                    batch.count  = 2'd0;
                    mode_next    = M_HEX;
                    hex_cnt_next = 2'd0;
                    hex_acc_next = 16'd0;
                end
                else
                begin
                    batch.r0  = mk(KIND_ERROR, 1'b0, 16'd0, ERR_ESCAPE, line_out);
                    mode_next = M_ERR_ESC;
                end
            end
            M_HEX:
            begin
                priority if (!hex_ok)
                begin
                    batch.count = 2'd1;
                    batch.r0    = mk(KIND_ERROR, 1'b0, 16'd0, ERR_HEX, line_out);
                    mode_next   = M_ERR_HEX;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    batch.count  = 2'd1;
                    batch.r0     = mk(KIND_CHAR, 1'b1, hex_acc_shift, ERR_NONE, line_out);
                    hex_cnt_next = 2'd0;
                    hex_acc_next = 16'd0;
                    mode_next    = M_STR;
                end
                else
                begin
                    hex_acc_next = hex_acc_shift;
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end
            end
            M_ERR_ESC:
            begin
                batch.count = 2'd1;
                batch.r0    = mk(KIND_ERROR, 1'b0, 16'd0, ERR_ESCAPE, line_out);
            end
            M_ERR_HEX:
            begin
                batch.count = 2'd1;
                batch.r0    = mk(KIND_ERROR, 1'b0, 16'd0, ERR_HEX, line_out);
            end
            M_ERR_OPEN:
            begin
                batch.count = 2'd1;
                batch.r0    = mk(KIND_ERROR, 1'b0, 16'd0, ERR_UNCLOSED, line_out);
            end
            default:
            begin
            end
        endcase
    end

    // Advance the lexer state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            hex_cnt_reg <= 2'd0;
            hex_acc_reg <= 16'd0;
            line_reg    <= LINE_BITS'(1);
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            hex_acc_reg <= hex_acc_next;
            line_reg    <= line_next;
        end
    end

endmodule

// ===== rtl/jtok_out_buf.sv =====
module jtok_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  jtok_pkg::tok_batch_t batch,
    output logic                 can_load,
    output logic                 out_valid,
    input  logic                 out_ready,
    output jtok_pkg::tok_res_t   out_res,
    output logic                 out_last
);
    import jtok_pkg::*;

    tok_res_t   head_reg;
    tok_res_t   tail_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign out_valid = cnt_reg != 2'd0;
    assign out_res   = head_reg;
    assign out_last  = cnt_reg == 2'd1;
    assign pop       = out_valid && out_ready;
    assign can_load  = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    // Hold the fill count; a load replaces whatever is drained this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result payload: load a whole batch, or shift the second entry forward
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            head_reg <= batch.r0;
            tail_reg <= batch.r1;
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import jtok_pkg::*;

    localparam int  DIR_ROWS       = 22;
    localparam int  RANDOM_END     = 1522;
    localparam int  NEWLINE_BURST  = 24;
    localparam int  HOLD_OFF_AT    = 400;
    localparam int  HOLD_OFF_LEN   = 300;
    localparam int  WATCHDOG_LIMIT = 5000;
    localparam logic [7:0] QUOTE   = 8'h22;
    localparam logic [7:0] BSLASH  = 8'h5C;
    localparam logic [7:0] LF      = 8'h0A;

    typedef enum logic [2:0] {
        LEX_IDLE,
        LEX_BARE,
        LEX_STR,
        LEX_ESC,
        LEX_HEX,
        LEX_ERR
    } lex_state_t;

    typedef struct packed {
        tok_res_t r;
        logic     last;
    } tok_item_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        chk;
        logic [2:0]  kind;
        logic        is_string;
        logic [15:0] value;
        logic [1:0]  error_code;
        logic [15:0] line;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [7:0]            s_data = 8'h00;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // Lexer state held by the predictor
    lex_state_t  lex_st = LEX_IDLE;
    logic [1:0]  hex_cnt = 2'd0;
    logic [15:0] hex_code = 16'h0000;
    logic [15:0] line_no = 16'd1;
    logic [1:0]  err_held = ERR_NONE;

    tok_item_t   fresh [2];
    int          n_fresh;
    tok_item_t   pending_tokens [$];

    int          bytes_sent = 0;
    int          bad_results = 0;
    int          quiet_cycles = 0;
    logic        held_off = 1'b0;
    logic        calm;

    dir_row_t    dir_rows [DIR_ROWS];

    json_tokenizer_unit #(.LINE_BITS(16)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    // No idling on either side within this window
    assign calm = (bytes_sent >= 800) && (bytes_sent < 1100);

    function automatic logic is_punct(input logic [7:0] c);
        return c == ":" || c == "," || c == "{" || c == "}" || c == "[" || c == "]";
    endfunction

    function automatic logic is_gap(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == LF;
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void emit_tok(input logic [2:0] kind, input logic str,
                                     input logic [15:0] value, input logic [1:0] err);
        fresh[n_fresh].r.kind       = kind;
        fresh[n_fresh].r.is_string  = str;
        fresh[n_fresh].r.value      = value;
        fresh[n_fresh].r.error_code = err;
        fresh[n_fresh].r.line       = line_no;
        fresh[n_fresh].last         = 1'b0;
        n_fresh++;
    endfunction

    function automatic void trip(input logic [1:0] code);
        lex_st   = LEX_ERR;
        err_held = code;
        emit_tok(KIND_ERROR, 1'b0, 16'h0000, code);
    endfunction

    // Work out the results of one accepted byte and queue them
    task automatic lex_byte(input logic [7:0] c);
        int hv;
        n_fresh = 0;
        if (lex_st == LEX_ERR)
        begin
            emit_tok(KIND_ERROR, 1'b0, 16'h0000, err_held);
        end
        else
        begin
            if (c == LF && line_no != 16'hFFFF)
                line_no = line_no + 16'd1;
            case (lex_st)
                LEX_IDLE:
                begin
                    if (c == 8'h00)
                        emit_tok(KIND_EOT, 1'b0, 16'h0000, ERR_NONE);
                    else if (is_gap(c))
                    begin
                    end
                    else if (is_punct(c))
                        emit_tok(KIND_PUNCT, 1'b0, {8'h00, c}, ERR_NONE);
                    else if (c == QUOTE)
                        lex_st = LEX_STR;
                    else
                    begin
                        emit_tok(KIND_CHAR, 1'b0, {8'h00, c}, ERR_NONE);
                        lex_st = LEX_BARE;
                    end
                end
                LEX_BARE:
                begin
                    if (c == 8'h00)
                    begin
                        emit_tok(KIND_END, 1'b0, 16'h0000, ERR_NONE);
                        emit_tok(KIND_EOT, 1'b0, 16'h0000, ERR_NONE);
                        lex_st = LEX_IDLE;
                    end
                    else if (is_gap(c))
                    begin
                        emit_tok(KIND_END, 1'b0, 16'h0000, ERR_NONE);
                        lex_st = LEX_IDLE;
                    end
                    else if (is_punct(c))
                    begin
                        emit_tok(KIND_END, 1'b0, 16'h0000, ERR_NONE);
                        emit_tok(KIND_PUNCT, 1'b0, {8'h00, c}, ERR_NONE);
                        lex_st = LEX_IDLE;
                    end
                    else if (c == QUOTE)
                    begin
                        emit_tok(KIND_END, 1'b0, 16'h0000, ERR_NONE);
                        lex_st = LEX_STR;
                    end
                    else
                        emit_tok(KIND_CHAR, 1'b0, {8'h00, c}, ERR_NONE);
                end
                LEX_STR:
                begin
                    if (c == 8'h00)
                        trip(ERR_UNCLOSED);
                    else if (c == BSLASH)
                        lex_st = LEX_ESC;
                    else if (c == QUOTE)
                    begin
                        emit_tok(KIND_END, 1'b1, 16'h0000, ERR_NONE);
                        lex_st = LEX_IDLE;
                    end
                    else
                        emit_tok(KIND_CHAR, 1'b1, {8'h00, c}, ERR_NONE);
                end
                LEX_ESC:
                begin
                    lex_st = LEX_STR;
                    case (c)
                        8'h00:              trip(ERR_UNCLOSED);
                        "b":                emit_tok(KIND_CHAR, 1'b1, 16'h0008, ERR_NONE);
                        "n":                emit_tok(KIND_CHAR, 1'b1, 16'h000A, ERR_NONE);
                        "r":                emit_tok(KIND_CHAR, 1'b1, 16'h000D, ERR_NONE);
                        "t":                emit_tok(KIND_CHAR, 1'b1, 16'h0009, ERR_NONE);
                        "/", BSLASH, QUOTE: emit_tok(KIND_CHAR, 1'b1, {8'h00, c}, ERR_NONE);
                        "u":
                        begin
                            lex_st   = LEX_HEX;
                            hex_cnt  = 2'd0;
                            hex_code = 16'h0000;
                        end
                        default:            trip(ERR_ESCAPE);
                    endcase
                end
                default:
                begin
                    // gather \u digits, the fourth one releases the code
                    hv = hex_val(c);
                    if (hv < 0)
                        trip(ERR_HEX);
                    else
                    begin
                        hex_code = {hex_code[11:0], hv[3:0]};
                        if (hex_cnt == 2'd3)
                        begin
                            emit_tok(KIND_CHAR, 1'b1, hex_code, ERR_NONE);
                            hex_cnt  = 2'd0;
                            hex_code = 16'h0000;
                            lex_st   = LEX_STR;
                        end
                        else
                            hex_cnt = hex_cnt + 2'd1;
                    end
                end
            endcase
        end
        if (n_fresh > 0)
            fresh[n_fresh-1].last = 1'b1;
        for (int k = 0; k < n_fresh; k++)
            pending_tokens.push_back(fresh[k]);
    endtask

    function automatic logic same_item(input tok_item_t a, input tok_item_t b);
        return a.r.kind === b.r.kind && a.r.is_string === b.r.is_string
            && a.r.value === b.r.value && a.r.error_code === b.r.error_code
            && a.r.line === b.r.line && a.last === b.last;
    endfunction

    task automatic note_mismatch(input string what, input tok_item_t exp_it,
                                 input tok_item_t got_it);
        bad_results++;
        if (bad_results <= 10)
        begin
            $display("%s: exp kind=%0d str=%0d val=%h err=%0d line=%0d last=%0d",
                     what, exp_it.r.kind, exp_it.r.is_string, exp_it.r.value,
                     exp_it.r.error_code, exp_it.r.line, exp_it.last);
            $display("    got kind=%0d str=%0d val=%h err=%0d line=%0d last=%0d",
                     got_it.r.kind, got_it.r.is_string, got_it.r.value,
                     got_it.r.error_code, got_it.r.line, got_it.last);
        end
    endtask

    // Offer one byte, hold it until the transfer completes, then predict
    task automatic push_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        lex_byte(b);
        bytes_sent++;
    endtask

    // Stop offering until every queued token has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (is_gap(b) || is_punct(b) || b == QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] hex_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10)
            return 8'("0" + v);
        return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    function automatic logic [7:0] punct_char();
        case ($urandom_range(0, 5))
            0:       return ":";
            1:       return ",";
            2:       return "{";
            3:       return "}";
            4:       return "[";
            default: return "]";
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 2))
            0:       return 8'h20;
            1:       return 8'h09;
            default: return 8'h0D;
        endcase
    endfunction

    // String body after the opening quote, with escapes, then the closing quote
    task automatic send_string_body();
        int n;
        int pick;
        logic [7:0] b;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                do
                    b = 8'($urandom_range(1, 255));
                while (b == BSLASH || b == QUOTE);
                push_byte(b);
            end
            else if (pick < 8)
            begin
                push_byte(BSLASH);
                case ($urandom_range(0, 6))
                    0:       push_byte("b");
                    1:       push_byte("n");
                    2:       push_byte("r");
                    3:       push_byte("t");
                    4:       push_byte("/");
                    5:       push_byte(BSLASH);
                    default: push_byte(QUOTE);
                endcase
            end
            else
            begin
                push_byte(BSLASH);
                push_byte("u");
                repeat (4) push_byte(hex_digit());
            end
        end
        push_byte(QUOTE);
    endtask

    // Bare word with a random terminator
    task automatic send_word();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) push_byte(word_char());
        case ($urandom_range(0, 4))
            0: push_byte(blank_char());
            1: push_byte(LF);
            2: push_byte(punct_char());
            3:
            begin
                push_byte(QUOTE);
                send_string_body();
            end
            default: push_byte(8'h00);
        endcase
    endtask

    task automatic send_segment();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_word();
        else if (pick < 55)
        begin
            push_byte(QUOTE);
            send_string_body();
        end
        else if (pick < 70)
            push_byte(punct_char());
        else if (pick < 80)
            push_byte($urandom_range(0, 1) ? LF : blank_char());
        else if (pick < 85)
            push_byte(8'h00);
        else
        begin
            // any byte; a lone quote gets its partner so no string stays open
            b = 8'($urandom_range(0, 255));
            push_byte(b);
            if (b == QUOTE)
                push_byte(QUOTE);
        end
    endtask

    // Receiver: random stalls, one long hold-off
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && bytes_sent >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            else
                m_ready <= calm || ($urandom_range(0, 99) >= 11);
        end
    end

    // Check each result transfer against the oldest queued token
    always @(posedge clk)
    begin : result_check
        tok_item_t got_it;
        tok_item_t exp_it;
        if (rst_n && m_axis_tvalid && m_ready)
        begin
            got_it.r.value      = m_axis_tdata[15:0];
            got_it.r.error_code = m_axis_tdata[17:16];
            got_it.r.line       = m_axis_tdata[33:18];
            got_it.r.kind       = m_axis_tuser[2:0];
            got_it.r.is_string  = m_axis_tuser[3];
            got_it.last         = m_axis_tlast;
            if (pending_tokens.size() == 0)
                note_mismatch("unexpected result", '0, got_it);
            else
            begin
                exp_it = pending_tokens.pop_front();
                if (!same_item(exp_it, got_it))
                    note_mismatch("result mismatch", exp_it, got_it);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        tok_item_t exp_it;
        logic      mid_drained;
        mid_drained = 1'b0;

        // byte, checked, kind, in string, value, error code, line
        dir_rows = '{
            '{8'h00, 1'b1, KIND_EOT,   1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{"{",   1'b1, KIND_PUNCT, 1'b0, 16'h007B, ERR_NONE, 16'd1},
            '{QUOTE, 1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{"k",   1'b1, KIND_CHAR,  1'b1, 16'h006B, ERR_NONE, 16'd1},
            '{BSLASH,1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{"u",   1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{"F",   1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{"f",   1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{"0",   1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{"9",   1'b1, KIND_CHAR,  1'b1, 16'hFF09, ERR_NONE, 16'd1},
            '{BSLASH,1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{QUOTE, 1'b1, KIND_CHAR,  1'b1, 16'h0022, ERR_NONE, 16'd1},
            '{BSLASH,1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{"n",   1'b1, KIND_CHAR,  1'b1, 16'h000A, ERR_NONE, 16'd1},
            '{QUOTE, 1'b1, KIND_END,   1'b1, 16'h0000, ERR_NONE, 16'd1},
            '{":",   1'b1, KIND_PUNCT, 1'b0, 16'h003A, ERR_NONE, 16'd1},
            '{8'hFF, 1'b1, KIND_CHAR,  1'b0, 16'h00FF, ERR_NONE, 16'd1},
            '{8'h01, 1'b1, KIND_CHAR,  1'b0, 16'h0001, ERR_NONE, 16'd1},
            '{"]",   1'b1, KIND_END,   1'b0, 16'h0000, ERR_NONE, 16'd1},
            '{LF,    1'b0, KIND_CHAR,  1'b0, 16'h0000, ERR_NONE, 16'd2},
            '{"t",   1'b1, KIND_CHAR,  1'b0, 16'h0074, ERR_NONE, 16'd2},
            '{8'h00, 1'b1, KIND_END,   1'b0, 16'h0000, ERR_NONE, 16'd2}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed rows cross-check the first result of the byte
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            push_byte(dir_rows[i].ch);
            if (dir_rows[i].chk)
            begin
                exp_it.r.kind       = dir_rows[i].kind;
                exp_it.r.is_string  = dir_rows[i].is_string;
                exp_it.r.value      = dir_rows[i].value;
                exp_it.r.error_code = dir_rows[i].error_code;
                exp_it.r.line       = dir_rows[i].line;
                exp_it.last         = fresh[0].last;
                if (n_fresh == 0 || !same_item(exp_it, fresh[0]))
                    note_mismatch("table row", exp_it, fresh[0]);
            end
        end
        wait_drained();

        // Random well-formed text with some noise
        while (bytes_sent < RANDOM_END)
        begin
            send_segment();
            if (!mid_drained && bytes_sent >= 700)
            begin
                wait_drained();
                mid_drained = 1'b1;
            end
        end

        // Close any bare word, then a run of blank lines
        push_byte(8'h20);
        repeat (NEWLINE_BURST) push_byte(LF);
        push_byte("a");
        push_byte("b");
        push_byte(8'h20);

        // Finish with one sticky error of a random kind
        push_byte(QUOTE);
        case ($urandom_range(0, 2))
            0:
            begin
                push_byte(BSLASH);
                push_byte("q");
            end
            1:
            begin
                push_byte(BSLASH);
                push_byte("u");
                push_byte(hex_digit());
                push_byte("g");
            end
            default:
            begin
                push_byte("x");
                push_byte(8'h00);
            end
        endcase
        repeat (6) push_byte(8'($urandom_range(0, 255)));

        wait_drained();
        if (bad_results == 0 && pending_tokens.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
